@@ rtl/single_source_shortest_path_defines.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
// implication checked at every clock edge outside reset
`define SSSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SSSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/sssp_pkg.sv @@
// Shared types and codes for the shortest path block.
// No dependencies.
`default_nettype none
package sssp_pkg;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned VID_W  = 4;
  localparam int unsigned WGT_W  = 16;
  localparam int unsigned DIST_W = 20;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_RUN   = 2'd2;

  localparam logic [0:0] REG_VCOUNT = 1'b0;
  localparam logic [0:0] REG_UNDIR  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic clear_edges;   // edge count to zero
    logic add_edge;      // store edge from input item
    logic init_run;      // reset run state, latch source
    logic sel_start;     // begin minimum selection
    logic sel_step;      // look at one vertex
    logic commit_pick;   // mark pick finished
    logic scan_start;    // begin edge scan
    logic scan_step;     // process one edge
    logic out_load;      // load result register for out_idx
    logic out_next;      // advance result index
  } sssp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sel_done;      // selection went over all vertices
    logic pick_valid;    // a vertex was found
    logic scan_done;     // all edges processed
    logic out_last;      // current result index is the final one
  } sssp_stat_t;
endpackage
`default_nettype wire

@@ rtl/single_source_shortest_path.sv @@
// Top level of the shortest path block: config registers, controller, datapath.
// Depends on sssp_pkg, sssp_ctrl, sssp_datapath.
//
//  channel | dir | payload
//  in_     | in  | tdata {source_vertex, weight, to_vertex, from_vertex, command}
//  out_    | out | tdata {reachable, distance, vertex}, tlast
//  cfg_    | in  | register write, index 0 vertex_count, 1 undirected
//
// A run, once accepted, repeats per finished vertex a minimum selection (one vertex a
// cycle) and an edge scan (one edge a cycle through the registered memory read), then
// a final selection that finds nothing, then one result per vertex in use, each held
// until taken. Input is refused during a run.
// Reset is synchronous, active low; the edge store is empty after it.
`default_nettype none
module single_source_shortest_path #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_EDGES    = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] command, [5:2] from_vertex, [9:6] to_vertex, [25:10] weight,
  // [29:26] source_vertex
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [3:0] vertex, [23:4] distance, [24] reachable
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  logic [4:0] vcount_r;
  logic       undir_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 5'd16;
      undir_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        sssp_pkg::REG_VCOUNT: vcount_r <= cfg_data;
        sssp_pkg::REG_UNDIR:  undir_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sssp_pkg::sssp_cmd_t  cmd;
  sssp_pkg::sssp_stat_t stat;
  logic [3:0]  res_vertex;
  logic [19:0] res_dist;
  logic        res_reach;

  wire logic in_acc  = in_tvalid && in_tready;
  wire logic out_acc = out_tvalid && out_tready;

  sssp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_acc(in_acc), .in_cmd(in_tdata[1:0]),
    .out_acc(out_acc), .stat(stat), .cmd(cmd), .in_rdy(in_tready),
    .out_vld(out_tvalid)
  );

  sssp_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .vcount(vcount_r), .undir(undir_r),
    .in_from(in_tdata[5:2]), .in_to(in_tdata[9:6]), .in_wgt(in_tdata[25:10]),
    .in_src(in_tdata[29:26]),
    .res_vertex(res_vertex), .res_dist(res_dist), .res_reach(res_reach),
    .res_last(out_tlast)
  );

  assign out_tdata = {7'd0, res_reach, res_dist, res_vertex};
endmodule
`default_nettype wire

@@ rtl/sssp_datapath.sv @@
// Datapath: edge memory, per-vertex distance state, selection and relax logic.
// Depends on sssp_pkg.
`default_nettype none
module sssp_datapath #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_EDGES    = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sssp_pkg::sssp_cmd_t           cmd,
  output sssp_pkg::sssp_stat_t               stat,
  input  wire logic [4:0]                    vcount,
  input  wire logic                          undir,
  input  wire logic [sssp_pkg::VID_W-1:0]    in_from,
  input  wire logic [sssp_pkg::VID_W-1:0]    in_to,
  input  wire logic [sssp_pkg::WGT_W-1:0]    in_wgt,
  input  wire logic [sssp_pkg::VID_W-1:0]    in_src,
  output logic [sssp_pkg::VID_W-1:0]         res_vertex,
  output logic [sssp_pkg::DIST_W-1:0]        res_dist,
  output logic                               res_reach,
  output logic                               res_last
);
  localparam int unsigned VI_W = $clog2(MAX_VERTICES);
  localparam int unsigned VC_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EI_W = $clog2(MAX_EDGES);
  localparam int unsigned EC_W = $clog2(MAX_EDGES + 1);
  localparam int unsigned DW   = sssp_pkg::DIST_W;
  localparam int unsigned VW   = sssp_pkg::VID_W;

  // effective vertex count, clamped into 1..MAX_VERTICES
  logic [VC_W-1:0] n_eff;
  always_comb begin
    if (vcount == 5'd0) n_eff = VC_W'(1);
    else if ({27'd0, vcount} > MAX_VERTICES) n_eff = VC_W'(MAX_VERTICES);
    else n_eff = VC_W'(vcount);
  end

  // edge memory
  logic [VW+VW+sssp_pkg::WGT_W-1:0] emem [MAX_EDGES];
  logic [VW+VW+sssp_pkg::WGT_W-1:0] erd_r;
  logic [EC_W-1:0] etotal_r;
  logic [EC_W-1:0] eidx_r;
  logic            erd_vld_r;

  // per-vertex state (fixed-place registers)
  logic [DW-1:0] dist_r  [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] known_r, fin_r;

  // selection
  logic [VC_W-1:0] sidx_r;
  logic [VI_W-1:0] pick_r;
  logic            pvld_r;
  logic [DW-1:0]   pdist_r;
  logic [VC_W-1:0] oidx_r;

  wire logic add_ok = ({1'b0, in_from} < (VW+1)'(n_eff)) && ({1'b0, in_to} < (VW+1)'(n_eff))
                      && (etotal_r < EC_W'(MAX_EDGES));
  wire logic src_ok = ({1'b0, in_src} < (VW+1)'(n_eff));

  always_ff @(posedge clk) begin
    if (cmd.add_edge && add_ok)
      emem[etotal_r[EI_W-1:0]] <= {in_from, in_to, in_wgt};
    erd_r <= emem[eidx_r[EI_W-1:0]];
  end

  // edge being relaxed (registered read)
  wire logic [VW-1:0] ea = erd_r[VW+VW+sssp_pkg::WGT_W-1 -: VW];
  wire logic [VW-1:0] eb = erd_r[VW+sssp_pkg::WGT_W-1 -: VW];
  wire logic [sssp_pkg::WGT_W-1:0] ew = erd_r[sssp_pkg::WGT_W-1:0];
  wire logic in_range = ({1'b0, ea} < (VW+1)'(n_eff)) && ({1'b0, eb} < (VW+1)'(n_eff));
  wire logic [DW-1:0] cand = pdist_r + DW'(ew);
  wire logic [VI_W-1:0] ea_i = VI_W'(ea);
  wire logic [VI_W-1:0] eb_i = VI_W'(eb);
  wire logic fwd = erd_vld_r && in_range && (ea_i == pick_r);
  wire logic bwd = erd_vld_r && in_range && undir && (eb_i == pick_r);
  wire logic sel_i_ok = known_r[sidx_r[VI_W-1:0]] && !fin_r[sidx_r[VI_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etotal_r  <= '0;
      erd_vld_r <= 1'b0;
    end else begin
      if (cmd.clear_edges) etotal_r <= '0;
      else if (cmd.add_edge && add_ok) etotal_r <= etotal_r + EC_W'(1);
      erd_vld_r <= cmd.scan_step && (eidx_r < etotal_r);
    end
    if (cmd.init_run) begin
      fin_r   <= '0;
      // only the source starts known, and only when it is in use
      known_r <= src_ok ? (MAX_VERTICES'(1) << in_src) : '0;
      if (src_ok) dist_r[VI_W'(in_src)] <= '0;
      oidx_r <= '0;
    end
    if (cmd.sel_start) begin
      sidx_r <= '0;
      pvld_r <= 1'b0;
    end else if (cmd.sel_step) begin
      if (sel_i_ok && (!pvld_r || dist_r[sidx_r[VI_W-1:0]] < pdist_r)) begin
        pick_r  <= sidx_r[VI_W-1:0];
        pdist_r <= dist_r[sidx_r[VI_W-1:0]];
        pvld_r  <= 1'b1;
      end
      sidx_r <= sidx_r + VC_W'(1);
    end
    if (cmd.commit_pick) fin_r[pick_r] <= 1'b1;
    if (cmd.scan_start) eidx_r <= '0;
    else if (cmd.scan_step && eidx_r < etotal_r) eidx_r <= eidx_r + EC_W'(1);
    // relaxation uses the pick distance, which is final once picked
    if (fwd && (!known_r[eb_i] || cand < dist_r[eb_i])) begin
      dist_r[eb_i]  <= cand;
      known_r[eb_i] <= 1'b1;
    end
    if (bwd && !(fwd && ea_i == eb_i) && (!known_r[ea_i] || cand < dist_r[ea_i])) begin
      dist_r[ea_i]  <= cand;
      known_r[ea_i] <= 1'b1;
    end
    if (cmd.out_load) begin
      res_vertex <= VW'(oidx_r);
      res_reach  <= known_r[oidx_r[VI_W-1:0]];
      res_dist   <= known_r[oidx_r[VI_W-1:0]] ? dist_r[oidx_r[VI_W-1:0]] : '0;
      res_last   <= (oidx_r + VC_W'(1)) == n_eff;
    end
    if (cmd.out_next) oidx_r <= oidx_r + VC_W'(1);
  end

  assign stat.sel_done   = (sidx_r == n_eff);
  assign stat.pick_valid = pvld_r;
  assign stat.scan_done  = (eidx_r == etotal_r) && !erd_vld_r;
  assign stat.out_last   = (oidx_r + VC_W'(1)) == n_eff;
endmodule
`default_nettype wire

@@ rtl/sssp_ctrl.sv @@
// Controller state machine: sequences selection, edge scan and result output.
// Depends on sssp_pkg.
`default_nettype none
module sssp_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_acc,
  input  wire logic [sssp_pkg::CMD_W-1:0] in_cmd,
  input  wire logic                       out_acc,
  input  wire sssp_pkg::sssp_stat_t       stat,
  output sssp_pkg::sssp_cmd_t             cmd,
  output logic                            in_rdy,
  output logic                            out_vld
);
  typedef enum logic [2:0] {S_IDLE, S_SEL, S_SCAN, S_LOAD, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic out_vld_r, out_vld_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    out_vld_nxt = out_vld_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            sssp_pkg::CMD_CLEAR: cmd.clear_edges = 1'b1;
            sssp_pkg::CMD_ADD:   cmd.add_edge = 1'b1;
            sssp_pkg::CMD_RUN: begin
              cmd.init_run = 1'b1;
              cmd.sel_start = 1'b1;
              state_nxt = S_SEL;
            end
            default: ;
          endcase
        end
      end
      S_SEL: begin
        if (!stat.sel_done) cmd.sel_step = 1'b1;
        else if (stat.pick_valid) begin
          cmd.commit_pick = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end else state_nxt = S_LOAD;
      end
      S_SCAN: begin
        if (!stat.scan_done) cmd.scan_step = 1'b1;
        else begin
          cmd.sel_start = 1'b1;
          state_nxt = S_SEL;
        end
      end
      S_LOAD: begin
        cmd.out_load = 1'b1;
        out_vld_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          out_vld_nxt = 1'b0;
          if (stat.out_last) state_nxt = S_IDLE;
          else begin
            cmd.out_next = 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_rdy  = (state_r == S_IDLE);
  assign out_vld = out_vld_r;
endmodule
`default_nettype wire

@@ rtl/sssp_checker.sv @@
// Port-level checker for the shortest path block, bound to the top level.
// Depends on single_source_shortest_path_defines.svh.
`default_nettype none
`include "single_source_shortest_path_defines.svh"
module sssp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  // never take input while a result is shown
  `SSSP_ASSERT_IMP(a_excl, clk, rst_n, out_tvalid, !in_tready)
  // unreachable results report zero distance
  `SSSP_ASSERT_IMP(a_unreach, clk, rst_n, out_tvalid && !out_tdata[24], out_tdata[23:4] == 20'd0)
  // stalled result holds
  `SSSP_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind single_source_shortest_path sssp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire
